### rtl/core/tlf_pkg.sv
// Shared types and constants of the timestamped low-pass filter.
package tlf_pkg;

	localparam int TC_BITS    = 16;
	localparam int STAMP_BITS = 32;
	localparam int STATE_FRAC = 8;
	localparam int DT_BITS    = 9;
	localparam int DEN_BITS   = TC_BITS + 1;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	localparam logic [STAMP_BITS-1:0] MAX_DT_MS      = 32'd500;
	localparam logic [DT_BITS-1:0]    FALLBACK_DT_MS = 9'd1;

	typedef enum logic {
		REG_TIME_CONSTANT = 1'b0,
		REG_START_TIME    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [TC_BITS-1:0]    tc;
		logic [STAMP_BITS-1:0] start_ms;
		logic                  load_stamp;
	} cfg_t;

endpackage

### rtl/core/timestamped_lowpass_filter_core.sv
// Top level of the timestamped first-order low-pass filter.
// A request passes through ST_PREP, which forms dt and Tf+dt, ST_DIV, where the
// radix-2 divider retires one of the ALPHA_FRAC_BITS+1 quotient bits per cycle,
// ST_MUL, which multiplies, and ST_FIN, which rounds, clamps and updates the state
// and waits while the output register is full. s_tready is low from acceptance
// until the result is written; a finished result waits in the output register
// while the next request is taken. Writing start_time_ms reloads the previous
// timestamp through a registered strobe; a request in ST_PREP takes priority.
module timestamped_lowpass_filter_core
	import tlf_pkg::*;
#(
	parameter int SAMPLE_BITS     = 24,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample_in, stamp_ms
	input  logic [((SAMPLE_BITS+STAMP_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// filtered_out
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [APB_AW-1:0]                    paddr,
	input  logic [APB_DW-1:0]                    pwdata,
	output logic [APB_DW-1:0]                    prdata,
	output logic                                 pready
);

	localparam int F    = ALPHA_FRAC_BITS;
	localparam int YW   = SAMPLE_BITS + STATE_FRAC;
	localparam int PW   = F + YW + 3;
	localparam int ODW  = ((SAMPLE_BITS + 7) / 8) * 8;

	localparam logic signed [YW+2:0] YMAX =
		{3'b000, 1'b0, {(SAMPLE_BITS-1){1'b1}}, {STATE_FRAC{1'b0}}};
	localparam logic signed [YW+2:0] YMIN = {3'b111, 1'b1, {(YW-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS:0] RMAX = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [PW-1:0] ACC_RND = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [YW:0] OUT_RND =
		{{(YW+1-STATE_FRAC){1'b0}}, 1'b1, {(STATE_FRAC-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                       state_q;
	cfg_t                         cfg;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [STAMP_BITS-1:0]        stamp_q;
	logic [STAMP_BITS-1:0]        prior_stamp_q;
	logic signed [YW-1:0]         y_q;
	logic [F:0]                   alpha_q;
	logic                         den_zero_q;
	logic signed [PW-1:0]         prod_q;
	logic                         out_valid_q;
	logic [SAMPLE_BITS-1:0]       out_data_q;

	logic [STAMP_BITS-1:0]        dt_raw;
	logic [DT_BITS-1:0]           dt;
	logic [DEN_BITS-1:0]          den;
	logic                         div_start;
	logic                         div_done;
	logic [F:0]                   quotient;
	logic signed [YW-1:0]         ux;
	logic signed [YW:0]           diff;
	logic signed [PW-1:0]         ux_ext;
	logic signed [PW-1:0]         acc;
	logic signed [YW+2:0]         y_full;
	logic signed [YW+2:0]         y_clamp;
	logic signed [YW-1:0]         y_new;
	logic [YW:0]                  r_sum;
	logic signed [SAMPLE_BITS:0]  r_full;
	logic [SAMPLE_BITS-1:0]       r_out;
	logic                         out_free;

	tlf_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlf_div #(
		.ALPHA_FRAC_BITS (F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.tc       (cfg.tc),
		.den      (den),
		.done     (div_done),
		.quotient (quotient)
	);

	// elapsed time, large gaps fall back to one millisecond
	assign dt_raw    = stamp_q - prior_stamp_q;
	assign dt        = (dt_raw > MAX_DT_MS) ? FALLBACK_DT_MS : dt_raw[DT_BITS-1:0];
	assign den       = {1'b0, cfg.tc} + {{(DEN_BITS-DT_BITS){1'b0}}, dt};
	assign div_start = (state_q == ST_PREP);

	// y = x + alpha*(y_prev - x), everything in Q.8 scaled by 2^F
	assign ux     = {x_q, {STATE_FRAC{1'b0}}};
	assign diff   = {y_q[YW-1], y_q} - {ux[YW-1], ux};
	assign ux_ext = {{(PW-YW){ux[YW-1]}}, ux};
	assign acc    = (ux_ext <<< F) + prod_q + ACC_RND;
	assign y_full = acc[PW-1:F];

	always_comb begin
		priority if (y_full > YMAX) begin
			y_clamp = YMAX;
		end else if (y_full < YMIN) begin
			y_clamp = YMIN;
		end else begin
			y_clamp = y_full;
		end
	end

	assign y_new  = y_clamp[YW-1:0];
	assign r_sum  = {y_new[YW-1], y_new} + OUT_RND;
	assign r_full = r_sum[YW:STATE_FRAC];
	assign r_out  = (r_full > RMAX) ? RMAX[SAMPLE_BITS-1:0] : r_full[SAMPLE_BITS-1:0];

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prior_stamp_q <= '0;
			y_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_PREP) begin
				prior_stamp_q <= stamp_q;
			end else if (cfg.load_stamp) begin
				prior_stamp_q <= cfg.start_ms;
			end
			if (state_q == ST_FIN && out_free) begin
				y_q         <= y_new;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register can take the result
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q     <= s_tdata[SAMPLE_BITS-1:0];
			stamp_q <= s_tdata[SAMPLE_BITS +: STAMP_BITS];
		end
		if (state_q == ST_PREP) begin
			den_zero_q <= (den == '0);
		end
		if (state_q == ST_DIV && div_done) begin
			alpha_q <= den_zero_q ? '0 : quotient;
		end
		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, alpha_q}) * diff;
		end
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= r_out;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = ODW'(out_data_q);

endmodule

### rtl/core/tlf_apb.sv
// Configuration register file behind the APB port.
module tlf_apb
	import tlf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [TC_BITS-1:0]    tc_q;
	logic [STAMP_BITS-1:0] start_q;
	logic                  load_q;
	logic                  wr_en;
	reg_idx_t              idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q    <= '0;
			start_q <= '0;
			load_q  <= 1'b0;
		end else begin
			load_q <= wr_en && (idx == REG_START_TIME);
			if (wr_en) begin
				unique case (idx)
					REG_TIME_CONSTANT: tc_q <= pwdata[TC_BITS-1:0];
					REG_START_TIME:    start_q <= pwdata[STAMP_BITS-1:0];
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_TIME_CONSTANT: prdata = {{(APB_DW-TC_BITS){1'b0}}, tc_q};
			REG_START_TIME:    prdata = start_q;
		endcase
	end

	assign cfg.tc         = tc_q;
	assign cfg.start_ms   = start_q;
	assign cfg.load_stamp = load_q;

endmodule

### rtl/core/tlf_div.sv
// Radix-2 restoring divider for alpha = Tf * 2^F / (Tf + dt), one quotient bit per cycle.
module tlf_div
	import tlf_pkg::*;
#(
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [TC_BITS-1:0]       tc,
	input  logic [DEN_BITS-1:0]      den,
	output logic                     done,
	output logic [ALPHA_FRAC_BITS:0] quotient
);

	localparam int RW = DEN_BITS + 1;
	localparam int CW = $clog2(ALPHA_FRAC_BITS + 1);

	logic [RW-1:0]            rem_q;
	logic [DEN_BITS-1:0]      den_q;
	logic [ALPHA_FRAC_BITS:0] quo_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [RW:0]              trial;
	logic                     ge;
	logic [RW-1:0]            rem_kept;

	// the kept remainder stays below the divisor, so twice it fits RW bits
	assign trial    = {1'b0, rem_q} - {2'b00, den_q};
	assign ge       = ~trial[RW];
	assign rem_kept = ge ? trial[RW-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ALPHA_FRAC_BITS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, tc};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_kept[RW-2:0], 1'b0};
			quo_q <= {quo_q[ALPHA_FRAC_BITS-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/tlf_check.sv
// Port-level checks of the filter core and their binding.
module tlf_check #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
	input logic                                 psel,
	input logic                                 pready
);

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the core stays busy after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("request taken while previous one still in work");

	// the register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low during a transfer");

	// a new result appears only when the core frees up for the next request
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result produced while core still busy");

endmodule

bind timestamped_lowpass_filter_core tlf_check #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_tlf_check (.*);
